>>> rtl/fpt_pkg.sv
// fpt_pkg: shared types, codes and constants of the focus point tracker
// used by fpt_ctrl, fpt_dpath and focus_point_tracker; no dependencies
package fpt_pkg;

   // command codes of an input word
   typedef enum logic [1:0] {
      CMD_TICK   = 2'd0,
      CMD_FOCUS  = 2'd1,
      CMD_FOLLOW = 2'd2,
      CMD_STOP   = 2'd3
   } cmd_type;

   // input word
   typedef struct packed {
      cmd_type            cmd;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] rate;
      logic        [31:0] dt;
      logic               follow_seen;
   } req_word_type;

   // result word
   typedef struct packed {
      logic signed [31:0] focus_x;
      logic signed [31:0] focus_y;
      logic               done_res;
   } rsp_word_type;

   // configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_INITIAL_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INITIAL_Y = 2'd1;

   typedef struct packed {
      logic                 en;
      logic [CSR_IDX_W-1:0] index;
      logic [31:0]          data;
   } csr_wr_type;

   // snap distance, 1e-3 in Q16.16
   localparam logic [32:0] EPS_RAW = 33'd66;

   // iteration counts, loaded as last index
   localparam int CNT_W = 6;
   localparam logic [CNT_W-1:0] SQRT_LAST = 6'd32;
   localparam logic [CNT_W-1:0] DIV_LAST  = 6'd31;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIFF,
      ST_MXX,
      ST_MYY,
      ST_MRD,
      ST_SQRT,
      ST_CMP,
      ST_MMX,
      ST_MMY,
      ST_NUMY,
      ST_DIV,
      ST_APPLY,
      ST_OUT
   } fsm_state_type;

   // datapath operations
   typedef enum logic [3:0] {
      OP_NONE,
      OP_ITEM,
      OP_SNAP_RATE,
      OP_DIFF,
      OP_MXX,
      OP_MYY,
      OP_MRD,
      OP_SQRT,
      OP_CMP,
      OP_MMX,
      OP_MMY,
      OP_NUMY,
      OP_DIV,
      OP_APPLY,
      OP_OUT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic rate_pos;
      logic near;
   } dp_status_type;

endpackage

>>> rtl/fpt_ctrl.sv
// fpt_ctrl: sequencer of the focus point tracker, handshakes and op issue
// depends on fpt_pkg
module fpt_ctrl import fpt_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  cmd_type       req_cmd,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type dp_status,
   output dp_cmd_type    dp_cmd
);

   fsm_state_type    state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // state, counter and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state and ops
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      dp_cmd.op    = OP_NONE;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               dp_cmd.op = OP_ITEM;
               if (req_cmd == CMD_TICK) state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            if (dp_status.rate_pos) begin
               dp_cmd.op = OP_DIFF;
               state_in  = ST_MXX;
            end else begin
               dp_cmd.op = OP_SNAP_RATE;
               state_in  = ST_OUT;
            end
         end
         ST_MXX: begin
            dp_cmd.op = OP_MXX;
            state_in  = ST_MYY;
         end
         ST_MYY: begin
            dp_cmd.op = OP_MYY;
            state_in  = ST_MRD;
         end
         ST_MRD: begin
            dp_cmd.op = OP_MRD;
            cnt_in    = SQRT_LAST;
            state_in  = ST_SQRT;
         end
         ST_SQRT: begin
            dp_cmd.op = OP_SQRT;
            if (cnt_ff == '0) state_in = ST_CMP;
            else cnt_in = cnt_ff - CNT_W'(1);
         end
         ST_CMP: begin
            dp_cmd.op = OP_CMP;
            state_in  = dp_status.near ? ST_OUT : ST_MMX;
         end
         ST_MMX: begin
            dp_cmd.op = OP_MMX;
            state_in  = ST_MMY;
         end
         ST_MMY: begin
            dp_cmd.op = OP_MMY;
            state_in  = ST_NUMY;
         end
         ST_NUMY: begin
            dp_cmd.op = OP_NUMY;
            cnt_in    = DIV_LAST;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            dp_cmd.op = OP_DIV;
            if (cnt_ff == '0) state_in = ST_APPLY;
            else cnt_in = cnt_ff - CNT_W'(1);
         end
         ST_APPLY: begin
            dp_cmd.op = OP_APPLY;
            state_in  = ST_OUT;
         end
         ST_OUT: begin
            // load result only when the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               dp_cmd.op    = OP_OUT;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> rtl/fpt_dpath.sv
// fpt_dpath: tracker state, shared 32x32 multiplier, bit-serial square root,
// two-lane restoring divider and result register; depends on fpt_pkg
module fpt_dpath import fpt_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  req_word_type  req_data,
   input  csr_wr_type    csr_wr,
   input  dp_cmd_type    dp_cmd,
   output dp_status_type dp_status,
   output rsp_word_type  rsp_data
);

   // architectural state
   logic [31:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [31:0] goal_x_ff, goal_x_in, goal_y_ff, goal_y_in;
   logic [31:0] step_rate_ff, step_rate_in;
   logic        following_ff, following_in, arrived_ff, arrived_in;

   // working registers
   logic [31:0] dt_ff, dt_in;
   logic [31:0] ax_ff, ax_in, ay_ff, ay_in;
   logic        negx_ff, negx_in, negy_ff, negy_in;
   logic [63:0] prod_ff, prod_in;
   logic [65:0] rad_ff, rad_in;
   logic [35:0] sq_rem_ff, sq_rem_in;
   logic [32:0] root_ff, root_in;
   logic [32:0] step_ff, step_in;
   logic [32:0] dvx_rem_ff, dvx_rem_in, dvy_rem_ff, dvy_rem_in;
   logic [31:0] dvx_lo_ff, dvx_lo_in, dvy_lo_ff, dvy_lo_in;
   rsp_word_type rsp_ff, rsp_in;

   // combinational helpers
   logic [32:0] dx, dy, dx_mag, dy_mag;
   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;
   logic [35:0] sq_t, sq_trial;
   logic        sq_ge;
   logic [33:0] dvx_t, dvy_t, dvx_d, dvy_d, div_d;
   logic        dvx_ge, dvy_ge;
   logic [31:0] num_a;
   logic [64:0] num_sum;

   // goal minus focus, exact in 33 bits
   assign dx     = {goal_x_ff[31], goal_x_ff} - {cur_x_ff[31], cur_x_ff};
   assign dy     = {goal_y_ff[31], goal_y_ff} - {cur_y_ff[31], cur_y_ff};
   assign dx_mag = dx[32] ? (33'd0 - dx) : dx;
   assign dy_mag = dy[32] ? (33'd0 - dy) : dy;

   // shared multiplier operand select
   always_comb begin
      mul_a = ax_ff;
      mul_b = ax_ff;
      case (dp_cmd.op)
         OP_MYY: begin
            mul_a = ay_ff;
            mul_b = ay_ff;
         end
         OP_MRD: begin
            mul_a = {1'b0, step_rate_ff[30:0]};
            mul_b = dt_ff;
         end
         OP_MMX: begin
            mul_a = ax_ff;
            mul_b = step_ff[31:0];
         end
         OP_MMY: begin
            mul_a = ay_ff;
            mul_b = step_ff[31:0];
         end
         default: begin
            mul_a = ax_ff;
            mul_b = ax_ff;
         end
      endcase
   end
   assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

   // one root bit per cycle
   assign sq_t     = {sq_rem_ff[33:0], rad_ff[65:64]};
   assign sq_trial = {1'b0, root_ff, 2'b01};
   assign sq_ge    = sq_t >= sq_trial;

   // one quotient bit per cycle on each lane, divisor is the distance
   assign div_d  = {1'b0, root_ff};
   assign dvx_t  = {dvx_rem_ff, dvx_lo_ff[31]};
   assign dvy_t  = {dvy_rem_ff, dvy_lo_ff[31]};
   assign dvx_ge = dvx_t >= div_d;
   assign dvy_ge = dvy_t >= div_d;
   assign dvx_d  = dvx_t - div_d;
   assign dvy_d  = dvy_t - div_d;

   // numerator |d|*step, step bit 32 added as a shifted magnitude
   assign num_a   = (dp_cmd.op == OP_NUMY) ? ay_ff : ax_ff;
   assign num_sum = {1'b0, prod_ff} + (step_ff[32] ? {1'b0, num_a, 32'd0} : 65'd0);

   // status to the sequencer
   assign dp_status.rate_pos = !step_rate_ff[31] && (step_rate_ff != 32'd0);
   assign dp_status.near     = ({15'd0, root_ff} <= prod_ff[63:16]) || (root_ff < EPS_RAW);

   // next values
   always_comb begin
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      goal_x_in    = goal_x_ff;
      goal_y_in    = goal_y_ff;
      step_rate_in = step_rate_ff;
      following_in = following_ff;
      arrived_in   = arrived_ff;
      dt_in        = dt_ff;
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      negx_in      = negx_ff;
      negy_in      = negy_ff;
      prod_in      = prod_ff;
      rad_in       = rad_ff;
      sq_rem_in    = sq_rem_ff;
      root_in      = root_ff;
      step_in      = step_ff;
      dvx_rem_in   = dvx_rem_ff;
      dvy_rem_in   = dvy_rem_ff;
      dvx_lo_in    = dvx_lo_ff;
      dvy_lo_in    = dvy_lo_ff;
      rsp_in       = rsp_ff;
      case (dp_cmd.op)
         OP_ITEM: begin
            case (req_data.cmd)
               CMD_TICK: begin
                  dt_in = req_data.dt;
                  if (following_ff && req_data.follow_seen) begin
                     goal_x_in = req_data.pos_x;
                     goal_y_in = req_data.pos_y;
                  end
               end
               CMD_FOCUS: begin
                  goal_x_in    = req_data.pos_x;
                  goal_y_in    = req_data.pos_y;
                  step_rate_in = req_data.rate;
                  following_in = 1'b0;
                  arrived_in   = 1'b0;
               end
               CMD_FOLLOW: begin
                  step_rate_in = req_data.rate;
                  following_in = 1'b1;
                  arrived_in   = 1'b0;
               end
               CMD_STOP: begin
                  following_in = 1'b0;
               end
               default: begin
                  following_in = following_ff;
               end
            endcase
         end
         OP_SNAP_RATE: begin
            cur_x_in   = goal_x_ff;
            cur_y_in   = goal_y_ff;
            arrived_in = 1'b1;
         end
         OP_DIFF: begin
            ax_in   = dx_mag[31:0];
            ay_in   = dy_mag[31:0];
            negx_in = dx[32];
            negy_in = dy[32];
         end
         OP_MXX: begin
            prod_in = mul_p;
         end
         OP_MYY: begin
            prod_in = mul_p;
            rad_in  = {2'b00, prod_ff};
         end
         OP_MRD: begin
            prod_in   = mul_p;
            rad_in    = rad_ff + {2'b00, prod_ff};
            sq_rem_in = '0;
            root_in   = '0;
         end
         OP_SQRT: begin
            rad_in = {rad_ff[63:0], 2'b00};
            if (sq_ge) begin
               sq_rem_in = sq_t - sq_trial;
               root_in   = {root_ff[31:0], 1'b1};
            end else begin
               sq_rem_in = sq_t;
               root_in   = {root_ff[31:0], 1'b0};
            end
         end
         OP_CMP: begin
            step_in = prod_ff[48:16];
            if (dp_status.near) begin
               cur_x_in   = goal_x_ff;
               cur_y_in   = goal_y_ff;
               arrived_in = !following_ff;
            end
         end
         OP_MMX: begin
            prod_in = mul_p;
         end
         OP_MMY: begin
            prod_in    = mul_p;
            dvx_rem_in = num_sum[64:32];
            dvx_lo_in  = num_sum[31:0];
         end
         OP_NUMY: begin
            dvy_rem_in = num_sum[64:32];
            dvy_lo_in  = num_sum[31:0];
         end
         OP_DIV: begin
            dvx_rem_in = dvx_ge ? dvx_d[32:0] : dvx_t[32:0];
            dvy_rem_in = dvy_ge ? dvy_d[32:0] : dvy_t[32:0];
            dvx_lo_in  = {dvx_lo_ff[30:0], dvx_ge};
            dvy_lo_in  = {dvy_lo_ff[30:0], dvy_ge};
         end
         OP_APPLY: begin
            cur_x_in = negx_ff ? (cur_x_ff - dvx_lo_ff) : (cur_x_ff + dvx_lo_ff);
            cur_y_in = negy_ff ? (cur_y_ff - dvy_lo_ff) : (cur_y_ff + dvy_lo_ff);
         end
         OP_OUT: begin
            rsp_in.focus_x  = cur_x_ff;
            rsp_in.focus_y  = cur_y_ff;
            rsp_in.done_res = arrived_ff;
         end
         default: begin
            rsp_in = rsp_ff;
         end
      endcase

      // configuration writes load focus and target on one axis and set done
      if (csr_wr.en) begin
         if (csr_wr.index == CSR_INITIAL_X) begin
            cur_x_in   = csr_wr.data;
            goal_x_in  = csr_wr.data;
            arrived_in = 1'b1;
         end else if (csr_wr.index == CSR_INITIAL_Y) begin
            cur_y_in   = csr_wr.data;
            goal_y_in  = csr_wr.data;
            arrived_in = 1'b1;
         end
      end
   end

   // tracker state
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff     <= '0;
         cur_y_ff     <= '0;
         goal_x_ff    <= '0;
         goal_y_ff    <= '0;
         step_rate_ff <= '0;
         following_ff <= 1'b0;
         arrived_ff   <= 1'b1;
      end else begin
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
         goal_x_ff    <= goal_x_in;
         goal_y_ff    <= goal_y_in;
         step_rate_ff <= step_rate_in;
         following_ff <= following_in;
         arrived_ff   <= arrived_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      dt_ff      <= dt_in;
      ax_ff      <= ax_in;
      ay_ff      <= ay_in;
      negx_ff    <= negx_in;
      negy_ff    <= negy_in;
      prod_ff    <= prod_in;
      rad_ff     <= rad_in;
      sq_rem_ff  <= sq_rem_in;
      root_ff    <= root_in;
      step_ff    <= step_in;
      dvx_rem_ff <= dvx_rem_in;
      dvy_rem_ff <= dvy_rem_in;
      dvx_lo_ff  <= dvx_lo_in;
      dvy_lo_ff  <= dvy_lo_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

>>> rtl/focus_point_tracker.sv
// focus_point_tracker: a tick moving toward its target runs 33 root steps
// and 32 divide steps; a near target skips the divide, rate <= 0 skips both.
// commands 1..3 are applied on accept and give no result; the next word is
// taken in the cycle after a result is loaded, even while that result waits.
// synchronous reset: focus and target 0, rate 0, not following, done set.
module focus_point_tracker import fpt_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_word_type         req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_word_type         rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_data
);

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;
   csr_wr_type    csr_wr;

   // configuration writes are always taken
   assign csr_ready    = 1'b1;
   assign csr_wr.en    = csr_valid;
   assign csr_wr.index = csr_index;
   assign csr_wr.data  = csr_data;

   // sequencer
   fpt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_data.cmd),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   // arithmetic and state
   fpt_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_wr    (csr_wr),
      .dp_cmd    (dp_cmd),
      .dp_status (dp_status),
      .rsp_data  (rsp_data)
   );

endmodule
